// ----- src/graph_depth_first_walk_macros.svh -----
// ----------------------------------------------------------------------------
// graph depth first walk assertion macros
// concurrent assertion wrappers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEPTH_FIRST_WALK_MACROS_SVH
`define GRAPH_DEPTH_FIRST_WALK_MACROS_SVH

// same-cycle implication
`ifndef SYNTH
`define GDFW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdfw assertion failed");
`else
`define GDFW_ASSERT_NOW(label, ante, cons)
`endif

// next-cycle implication
`ifndef SYNTH
`define GDFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdfw assertion failed");
`else
`define GDFW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/gdfw_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfw_pkg
// shared sizes, types and helpers of the depth first walk block
// ----------------------------------------------------------------------------
package gdfw_pkg;

    localparam int NODES       = 32;
    localparam int NODE_W      = 5;
    localparam int DEPTH_W     = 6;
    localparam int MAX_RESULTS = 32;

    // command codes on the action field
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    typedef logic [NODES-1:0]   t_row;
    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [DEPTH_W-1:0] t_depth;

    // priority encoder, lowest set bit wins
    function automatic t_node lowest_set(input t_row bits);
        t_node idx;
        idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/graph_depth_first_walk.sv -----
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// undirected graph in an adjacency ram, depth first walk with a ram stack
// ----------------------------------------------------------------------------
//  channel   signals                              handshake
//  command   i_action, i_node_a, i_node_b         start high while busy low
//  result    o_visited_node, o_last               o_valid strobe, one cycle
//
//  an add-edge word keeps busy high while it writes the first row, then
//  reads and writes the second row.
//  a walk keeps busy high through an eval state for each new node and each
//  pop, and a stack read state after every pop but the last, since both
//  rams return registered read data.
//  the last result strobes in the cycle busy drops.
//  reset clears the graph at once through one valid flag per row, no sweep.
//  the receiver cannot stall; each result is driven for exactly one cycle.
// ----------------------------------------------------------------------------
`include "graph_depth_first_walk_macros.svh"

module graph_depth_first_walk
    import gdfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_visited_node,
    output logic              o_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_E_WRA  = 3'd1;
    localparam logic [2:0] S_E_RDB  = 3'd2;
    localparam logic [2:0] S_E_WRB  = 3'd3;
    localparam logic [2:0] S_W_EV   = 3'd4;
    localparam logic [2:0] S_W_POPD = 3'd5;

    logic [2:0] r_state, n_state;
    t_row       r_row_vld, n_row_vld;
    t_row       r_visited, n_visited;
    t_depth     r_depth, n_depth;
    t_depth     r_count, n_count;
    t_node      r_node_a, n_node_a;
    t_node      r_node_b, n_node_b;
    t_node      r_rd_addr;
    t_node      r_pend, n_pend;
    logic       r_out_valid, n_out_valid;
    t_node      r_out_node, n_out_node;
    logic       r_out_last, n_out_last;

    // adjacency ram ports
    logic  adj_we;
    t_node adj_waddr;
    t_row  adj_wdata;
    t_node adj_raddr;
    t_row  adj_rdata;
    t_row  row;

    // stack ram ports
    logic  stk_we;
    t_node stk_waddr;
    t_node stk_wdata;
    t_node stk_raddr;
    t_node stk_rdata;

    t_row   cand;
    t_node  next_node;
    t_depth depth_m2;

    gdfw_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gdfw_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // a row never written reads as empty
    assign row       = r_row_vld[r_rd_addr] ? adj_rdata : '0;
    assign cand      = row & ~r_visited;
    assign next_node = lowest_set(cand);
    assign depth_m2  = r_depth - t_depth'(2);

    always_comb begin
        n_state     = r_state;
        n_row_vld   = r_row_vld;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_count     = r_count;
        n_node_a    = r_node_a;
        n_node_b    = r_node_b;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out_node  = r_out_node;
        n_out_last  = r_out_last;
        adj_we      = 1'b0;
        adj_waddr   = r_node_a;
        adj_wdata   = row;
        adj_raddr   = r_rd_addr;
        stk_we      = 1'b0;
        stk_waddr   = r_depth[NODE_W-1:0];
        stk_wdata   = next_node;
        stk_raddr   = depth_m2[NODE_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_node_a  = i_node_a;
                    n_node_b  = i_node_b;
                    adj_raddr = i_node_a;
                    if (i_action == ACT_EDGE) begin
                        n_state = S_E_WRA;
                    end else begin
                        n_visited    = '0;
                        n_visited[i_node_a] = 1'b1;
                        stk_we       = 1'b1;
                        stk_waddr    = '0;
                        stk_wdata    = i_node_a;
                        n_depth      = t_depth'(1);
                        n_count      = t_depth'(1);
                        n_pend       = i_node_a;
                        n_state      = S_W_EV;
                    end
                end
            end
            S_E_WRA: begin
                adj_we    = 1'b1;
                adj_waddr = r_node_a;
                adj_wdata = row | (t_row'(1) << r_node_b);
                n_row_vld[r_node_a] = 1'b1;
                n_state   = S_E_RDB;
            end
            S_E_RDB: begin
                adj_raddr = r_node_b;
                n_state   = S_E_WRB;
            end
            S_E_WRB: begin
                adj_we    = 1'b1;
                adj_waddr = r_node_b;
                adj_wdata = row | (t_row'(1) << r_node_a);
                n_row_vld[r_node_b] = 1'b1;
                n_state   = S_IDLE;
            end
            S_W_EV: begin
                if ((cand != '0) && (r_count < t_depth'(MAX_RESULTS))) begin
                    n_visited[next_node] = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_node  = r_pend;
                    n_out_last  = 1'b0;
                    n_pend      = next_node;
                    n_count     = r_count + t_depth'(1);
                    if (r_depth < t_depth'(NODES)) begin
                        stk_we    = 1'b1;
                        n_depth   = r_depth + t_depth'(1);
                        adj_raddr = next_node;
                    end
                end else begin
                    n_depth = r_depth - t_depth'(1);
                    if (r_depth == t_depth'(1)) begin
                        n_out_valid = 1'b1;
                        n_out_node  = r_pend;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        // new top of stack arrives next cycle
                        n_state = S_W_POPD;
                    end
                end
            end
            S_W_POPD: begin
                adj_raddr = stk_rdata;
                n_state   = S_W_EV;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_vld   <= '0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_vld   <= n_row_vld;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node_a   <= n_node_a;
        r_node_b   <= n_node_b;
        r_pend     <= n_pend;
        r_rd_addr  <= adj_raddr;
        r_out_node <= n_out_node;
        r_out_last <= n_out_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_visited_node = r_out_node;
    assign o_last         = r_out_last;

    `GDFW_ASSERT_NEXT(a_strobe_from_eval, r_state != S_W_EV, !o_valid)
    `GDFW_ASSERT_NOW(a_last_ends_walk, o_valid && o_last, r_state == S_IDLE)
    `GDFW_ASSERT_NOW(a_idle_stack_empty, r_state == S_IDLE, r_depth == '0)
    `GDFW_ASSERT_NOW(a_top_visited, r_state == S_W_EV, r_visited[r_rd_addr])
    `GDFW_ASSERT_NOW(a_depth_bound, r_state == S_W_EV, r_depth <= t_depth'(NODES))

endmodule

// ----- src/gdfw_ram.sv -----
// ----------------------------------------------------------------------------
// gdfw_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module gdfw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for graph_depth_first_walk
// feeds edge and walk words, predicts every visit with its own graph copy,
// and checks each visit strobe in order against the predicted walk
// ----------------------------------------------------------------------------
module testbench
    import gdfw_pkg::*;
();

    typedef struct {
        logic    action;
        t_node   node_a;
        t_node   node_b;
        logic    drain;
    } t_cmd_word;

    typedef struct {
        t_node node;
        logic  last;
    } t_visit;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    t_node       i_node_a = '0;
    t_node       i_node_b = '0;
    logic        o_valid;
    t_node       o_visited_node;
    logic        o_last;

    t_cmd_word   cmd_queue[$];
    t_visit      visit_expect[$];
    t_row        graph_rows[NODES] = '{default: '0};

    logic        cmd_accepted = 1'b0;
    int          total_words = 0;
    int          sent_cnt = 0;
    int          accepted_cnt = 0;
    int          edge_words = 0;
    int          walk_words = 0;
    int          visits_checked = 0;
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;

    graph_depth_first_walk dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .o_valid        (o_valid),
        .o_visited_node (o_visited_node),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    function automatic void queue_word(input logic act, input int a, input int b,
                                       input logic drain);
        t_cmd_word w;
        w.action = act;
        w.node_a = t_node'(a);
        w.node_b = t_node'(b);
        w.drain  = drain;
        cmd_queue = {cmd_queue, w};
    endfunction

    // depth first walk, always stepping to the lowest unvisited neighbor
    function automatic void predict_walk(input t_node origin);
        t_row   seen;
        t_node  stack_nodes[NODES];
        t_node  order[NODES];
        int     depth;
        int     count;
        int     nxt;
        t_node  top;
        t_visit v;
        seen = '0;
        seen[origin] = 1'b1;
        stack_nodes[0] = origin;
        order[0] = origin;
        depth = 1;
        count = 1;
        while (depth > 0) begin
            top = stack_nodes[depth-1];
            nxt = -1;
            for (int i = 0; i < NODES && nxt < 0; i++) begin
                if (graph_rows[top][i] && !seen[i]) begin
                    nxt = i;
                end
            end
            if (nxt < 0 || count >= MAX_RESULTS) begin
                depth--;
            end else begin
                seen[nxt] = 1'b1;
                if (depth < NODES) begin
                    stack_nodes[depth] = t_node'(nxt);
                    depth++;
                end
                order[count] = t_node'(nxt);
                count++;
            end
        end
        for (int i = 0; i < count; i++) begin
            v.node = order[i];
            v.last = (i == count - 1);
            visit_expect = {visit_expect, v};
        end
    endfunction

    function automatic void predict_word(input logic act, input t_node a, input t_node b);
        if (act == ACT_EDGE) begin
            graph_rows[a][b] = 1'b1;
            graph_rows[b][a] = 1'b1;
            edge_words++;
        end else begin
            predict_walk(a);
            walk_words++;
        end
    endfunction

    // monitor: check visits, record accepted words, watch for a hang
    always @(posedge i_clk) begin : watch_block
        t_visit exp_visit;
        if (i_rst_n) begin
            cmd_accepted = start && !busy;
            if (o_valid) begin
                if (visit_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected visit node %0d last %0b",
                                              o_visited_node, o_last));
                end else begin
                    exp_visit = visit_expect.pop_front();
                    visits_checked++;
                    if (o_visited_node !== exp_visit.node) begin
                        report_mismatch($sformatf("visited_node %0d, predicted %0d",
                                                  o_visited_node, exp_visit.node));
                    end
                    if (o_last !== exp_visit.last) begin
                        report_mismatch($sformatf("last %0b on node %0d, predicted %0b",
                                                  o_last, o_visited_node, exp_visit.last));
                    end
                end
            end
            if (cmd_accepted) begin
                predict_word(i_action, i_node_a, i_node_b);
                accepted_cnt++;
            end
            if (cmd_accepted || o_valid) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // driver: one word from the queue per handshake, random idle by phase
    always @(negedge i_clk) begin : drive_block
        t_cmd_word w;
        int        idle_pct;
        logic      send;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !cmd_accepted)) begin
            case ((sent_cnt * 5) / (total_words + 1))
                1: idle_pct = 54;
                2: idle_pct = 19;
                3: idle_pct = 54;
                default: idle_pct = 0;
            endcase
            send = 1'b0;
            if (cmd_queue.size() > 0) begin
                send = !(cmd_queue[0].drain && visit_expect.size() != 0)
                       && ($urandom_range(99) >= idle_pct);
            end
            if (send) begin
                w = cmd_queue.pop_front();
                start    <= 1'b1;
                i_action <= w.action;
                i_node_a <= w.node_a;
                i_node_b <= w.node_b;
                sent_cnt++;
            end else begin
                start    <= 1'b0;
                i_action <= 1'($urandom);
                i_node_a <= t_node'($urandom);
                i_node_b <= t_node'($urandom);
            end
        end
    end

    initial begin
        int span;
        int a;
        int b;

        // empty graph: isolated starts at both extremes, node_b ignored
        queue_word(ACT_WALK, 0, 31, 1'b0);
        queue_word(ACT_WALK, 31, 0, 1'b0);
        // self-loop keeps the node isolated
        queue_word(ACT_EDGE, 5, 5, 1'b0);
        queue_word(ACT_WALK, 5, 0, 1'b0);
        // two triangles joined at node 31, one on the extremes, duplicates in both directions
        queue_word(ACT_EDGE, 0, 31, 1'b0);
        queue_word(ACT_EDGE, 31, 16, 1'b0);
        queue_word(ACT_EDGE, 16, 0, 1'b0);
        queue_word(ACT_EDGE, 31, 2, 1'b0);
        queue_word(ACT_EDGE, 2, 7, 1'b0);
        queue_word(ACT_EDGE, 7, 31, 1'b0);
        queue_word(ACT_EDGE, 31, 0, 1'b0);
        queue_word(ACT_EDGE, 10, 21, 1'b0);
        queue_word(ACT_EDGE, 21, 10, 1'b0);
        queue_word(ACT_EDGE, 21, 21, 1'b0);
        queue_word(ACT_WALK, 31, 0, 1'b0);
        queue_word(ACT_WALK, 0, 31, 1'b0);
        queue_word(ACT_WALK, 16, 0, 1'b1);
        queue_word(ACT_WALK, 10, 5, 1'b0);
        queue_word(ACT_WALK, 21, 21, 1'b0);
        queue_word(ACT_WALK, 30, 0, 1'b0);

        // random part: edges start among low nodes and spread out, so
        // components stay apart for a while before the graph closes up
        for (int k = 0; k < 210; k++) begin
            span = 7 + (k * 24) / 210;
            if ($urandom_range(99) < 55) begin
                if ($urandom_range(9) == 0) begin
                    a = $urandom_range(31);
                    b = $urandom_range(31);
                end else begin
                    a = $urandom_range(span);
                    b = $urandom_range(span);
                end
                if ($urandom_range(19) == 0) begin
                    b = a;
                end
                queue_word(ACT_EDGE, a, b, (k % 45) == 44);
            end else begin
                queue_word(ACT_WALK, $urandom_range(31), $urandom_range(31), (k % 45) == 44);
            end
        end
        total_words = cmd_queue.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_words) @(posedge i_clk);
        while (visit_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        while (visit_expect.size() != 0) begin
            report_mismatch($sformatf("visit node %0d never came", visit_expect[0].node));
            void'(visit_expect.pop_front());
        end
        $display("covered %0d edge words and %0d walks, %0d visits checked",
                 edge_words, walk_words, visits_checked);
        $display("idle phases none/heavy/light, drained pauses, %0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/gdfw_pkg.sv
src/gdfw_ram.sv
src/graph_depth_first_walk.sv
tb/sv/testbench.sv
